@@ rtl/core/smtp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package smtp_pkg;

  // Depth of the job queue between the list tracker and the product unit.
  localparam int QUEUE_DEPTH = 2;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

@@ rtl/core/smtp_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface smtp_in_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           final_item;

  modport source (output valid, sample, final_item, input ready);
  modport sink   (input valid, sample, final_item, output ready);
endinterface

`default_nettype wire

@@ rtl/core/smtp_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface smtp_out_if #(
  parameter int PRODUCT_WIDTH = 47
) ();
  logic                            valid;
  logic                            ready;
  logic signed [PRODUCT_WIDTH-1:0] best_product;
  logic                            too_few;

  modport source (output valid, best_product, too_few, input ready);
  modport sink   (input valid, best_product, too_few, output ready);
endinterface

`default_nettype wire

@@ rtl/core/streaming_max_triplet_product_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Streaming maximum product of three. Samples arrive as items on in_ch, each
// with final_item marking the last sample of a set; a set yields exactly one
// item on out_ch holding the largest product of any three of its samples
// (best_product, 3*SAMPLE_WIDTH-1 bits signed), or 0 with too_few set when
// the set had fewer than three samples. The front tracker takes one sample
// per cycle while the job queue (two entries) has room. Each set's products
// are then worked out by the back unit in order: pop, two multiply steps,
// add, compare, present, plus any wait on out_ch.ready. The back unit takes
// a new job only once it is back in idle, so back-to-back short sets are
// limited by that product unit; a set of fewer than three samples skips the
// multiplies there (pop, present).
module streaming_max_triplet_product_unit #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  smtp_in_if.sink      in_ch,
  smtp_out_if.source   out_ch
);
  import smtp_pkg::*;

  // job word: too_few flag, three largest, two smallest
  localparam int JOB_WIDTH = 5 * SAMPLE_WIDTH + 1;

  q_status_t            q_status;
  logic                 push, pop;
  logic [JOB_WIDTH-1:0] push_job, pop_job;

  // list tracking, one sample per accepted item
  smtp_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .JOB_WIDTH    (JOB_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  // decouples the tracker from the product unit
  smtp_queue #(
    .JOB_WIDTH (JOB_WIDTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  // multi-cycle product evaluation and output register
  smtp_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .JOB_WIDTH    (JOB_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .pop_job  (pop_job),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

@@ rtl/core/smtp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Tracks the three largest and two smallest samples of the running set.
// On the last item of a set it pushes a job and clears the lists.
module smtp_front #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int JOB_WIDTH    = 5 * SAMPLE_WIDTH + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  smtp_in_if.sink                    in_ch,
  input  wire smtp_pkg::q_status_t   q_status,
  output logic                       push,
  output logic [JOB_WIDTH-1:0]       push_job
);
  import smtp_pkg::*;

  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [1:0] CNT_SAT = 2'd3;

  logic signed [SAMPLE_WIDTH-1:0] l0_r, l1_r, l2_r, s0_r, s1_r;
  logic signed [SAMPLE_WIDTH-1:0] l0_nxt, l1_nxt, l2_nxt, s0_nxt, s1_nxt;
  logic [1:0]                     cnt_r, cnt_nxt;
  logic signed [SAMPLE_WIDTH-1:0] v;
  logic                           accept;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign v           = in_ch.sample;

  always_comb begin
    l0_nxt = l0_r;
    l1_nxt = l1_r;
    l2_nxt = l2_r;
    if (v > l0_r) begin
      l2_nxt = l1_r;
      l1_nxt = l0_r;
      l0_nxt = v;
    end else if (v > l1_r) begin
      l2_nxt = l1_r;
      l1_nxt = v;
    end else if (v > l2_r) begin
      l2_nxt = v;
    end

    s0_nxt = s0_r;
    s1_nxt = s1_r;
    if (v < s0_r) begin
      s1_nxt = s0_r;
      s0_nxt = v;
    end else if (v < s1_r) begin
      s1_nxt = v;
    end

    cnt_nxt = (cnt_r == CNT_SAT) ? cnt_r : cnt_r + 2'd1;
  end

  assign push     = accept && in_ch.final_item;
  assign push_job = {(cnt_nxt != CNT_SAT), l0_nxt, l1_nxt, l2_nxt, s0_nxt, s1_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      l0_r  <= SMIN;
      l1_r  <= SMIN;
      l2_r  <= SMIN;
      s0_r  <= SMAX;
      s1_r  <= SMAX;
      cnt_r <= 2'd0;
    end else if (accept) begin
      l0_r  <= l0_nxt;
      l1_r  <= l1_nxt;
      l2_r  <= l2_nxt;
      s0_r  <= s0_nxt;
      s1_r  <= s1_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/smtp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Small job FIFO between list tracking and product evaluation.
module smtp_queue #(
  parameter int JOB_WIDTH = 81
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire logic [JOB_WIDTH-1:0]  push_job,
  input  wire logic                  pop,
  output logic [JOB_WIDTH-1:0]       pop_job,
  output smtp_pkg::q_status_t        status
);
  import smtp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

  logic [JOB_WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wp_r, rp_r;
  logic [CNT_W-1:0]     cnt_r;

  assign status.full  = (cnt_r == DEPTH_C);
  assign status.empty = (cnt_r == '0);
  assign pop_job      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == LAST_P) ? '0 : wp_r + PTR_W'(1);
      if (pop)  rp_r <= (rp_r == LAST_P) ? '0 : rp_r + PTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && status.full))
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && status.empty))
    else $error("job popped from empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("queue count did not advance on push");

endmodule

`default_nettype wire

@@ rtl/core/smtp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Evaluates both candidate products of one job and presents the larger, or 0 for a too-few job.
module smtp_back #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int JOB_WIDTH    = 5 * SAMPLE_WIDTH + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire smtp_pkg::q_status_t   q_status,
  input  wire logic [JOB_WIDTH-1:0]  pop_job,
  output logic                       pop,
  smtp_out_if.source                 out_ch
);
  import smtp_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = 3 * SW - 1;
  localparam int FW = 3 * SW + 1;

  typedef enum logic [2:0] {B_IDLE, B_MUL1, B_MUL2, B_SUM, B_CMP, B_OUT} bstate_t;

  bstate_t state_r;
  logic signed [SW-1:0]   l0_r, l1_r, l2_r, s0_r, s1_r;
  logic signed [2*SW-1:0] pt_r, pm_r, thi_r, mhi_r;
  logic signed [2*SW:0]   tlo_r, mlo_r;
  logic signed [FW-1:0]   top_r, mix_r;
  logic [PW-1:0]          prod_r;
  logic                   tf_r, valid_r;

  logic signed [2*SW-1:0] pt_c, pm_c, thi_c, mhi_c;
  logic signed [2*SW:0]   tlo_c, mlo_c;
  logic signed [FW-1:0]   top_c, mix_c;

  assign pop = (state_r == B_IDLE) && !q_status.empty;

  always_comb begin
    pt_c  = l0_r * l1_r;
    pm_c  = s0_r * s1_r;
    // second multiply split into low (unsigned) and high (signed) halves
    tlo_c = $signed({1'b0, pt_r[SW-1:0]}) * l2_r;
    thi_c = $signed(pt_r[2*SW-1:SW]) * l2_r;
    mlo_c = $signed({1'b0, pm_r[SW-1:0]}) * l0_r;
    mhi_c = $signed(pm_r[2*SW-1:SW]) * l0_r;
    top_c = $signed({thi_r[2*SW-1], thi_r, {SW{1'b0}}}) + $signed({{SW{tlo_r[2*SW]}}, tlo_r});
    mix_c = $signed({mhi_r[2*SW-1], mhi_r, {SW{1'b0}}}) + $signed({{SW{mlo_r[2*SW]}}, mlo_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (pop) begin
            {tf_r, l0_r, l1_r, l2_r, s0_r, s1_r} <= pop_job;
            if (pop_job[JOB_WIDTH-1]) begin
              prod_r  <= '0;
              valid_r <= 1'b1;
              state_r <= B_OUT;
            end else begin
              state_r <= B_MUL1;
            end
          end
        end
        B_MUL1: begin
          pt_r    <= pt_c;
          pm_r    <= pm_c;
          state_r <= B_MUL2;
        end
        B_MUL2: begin
          tlo_r   <= tlo_c;
          thi_r   <= thi_c;
          mlo_r   <= mlo_c;
          mhi_r   <= mhi_c;
          state_r <= B_SUM;
        end
        B_SUM: begin
          top_r   <= top_c;
          mix_r   <= mix_c;
          state_r <= B_CMP;
        end
        B_CMP: begin
          prod_r  <= (top_r > mix_r) ? top_r[PW-1:0] : mix_r[PW-1:0];
          valid_r <= 1'b1;
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (out_ch.ready) begin
            valid_r <= 1'b0;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.best_product = $signed(prod_r);
  assign out_ch.too_few      = tf_r;

endmodule

`default_nettype wire

@@ sim/tb_streaming_max_triplet_product_unit.sv @@
`timescale 1ns / 1ps

module tb_streaming_max_triplet_product_unit;

  localparam int SW = 16;
  localparam int PW = 3 * SW - 1;
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 16;
  localparam int ITEMS_PER_PHASE = 365;

  typedef struct {
    logic signed [PW-1:0] product;
    logic                 too_few;
  } product_item_t;

  logic clk = 1'b0;
  logic rst_n;

  smtp_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
  smtp_out_if #(.PRODUCT_WIDTH(PW)) out_ch ();

  streaming_max_triplet_product_unit #(.SAMPLE_WIDTH(SW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // tracker mirror: three largest (descending), two smallest (ascending)
  logic signed [SW-1:0] top_vals [3];
  logic signed [SW-1:0] low_vals [2];
  logic [1:0]           seen_cnt;

  product_item_t pending_products [$];
  int  error_count = 0;
  int  sent_items = 0;
  int  src_idle_pct = 0;
  int  snk_idle_pct = 0;
  int  quiet_cycles = 0;

  task automatic clear_tracker();
    top_vals[0] = S_MIN;
    top_vals[1] = S_MIN;
    top_vals[2] = S_MIN;
    low_vals[0] = S_MAX;
    low_vals[1] = S_MAX;
    seen_cnt    = 2'd0;
  endtask

  // Mirror of one accepted sample; queues a product at the end of a set.
  task automatic track_sample(input logic signed [SW-1:0] s, input logic fin);
    product_item_t exp_item;
    longint        a0, a1, a2, b0, b1, top_prod, mixed_prod, best;
    if (s > top_vals[0]) begin
      top_vals[2] = top_vals[1];
      top_vals[1] = top_vals[0];
      top_vals[0] = s;
    end else if (s > top_vals[1]) begin
      top_vals[2] = top_vals[1];
      top_vals[1] = s;
    end else if (s > top_vals[2]) begin
      top_vals[2] = s;
    end
    if (s < low_vals[0]) begin
      low_vals[1] = low_vals[0];
      low_vals[0] = s;
    end else if (s < low_vals[1]) begin
      low_vals[1] = s;
    end
    if (seen_cnt != 2'd3) seen_cnt = seen_cnt + 2'd1;
    if (fin) begin
      if (seen_cnt != 2'd3) begin
        exp_item.product = '0;
        exp_item.too_few = 1'b1;
      end else begin
        a0 = top_vals[0];
        a1 = top_vals[1];
        a2 = top_vals[2];
        b0 = low_vals[0];
        b1 = low_vals[1];
        top_prod   = a0 * a1 * a2;
        mixed_prod = a0 * b0 * b1;
        best = (top_prod > mixed_prod) ? top_prod : mixed_prod;
        exp_item.product = best[PW-1:0];
        exp_item.too_few = 1'b0;
      end
      pending_products.push_back(exp_item);
      clear_tracker();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // input side: every accepted item goes through the mirror
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      track_sample(in_ch.sample, in_ch.final_item);
  end

  // result side: compare with the oldest queued product
  always @(posedge clk) begin
    product_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_products.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_ch.best_product), 64'd0);
      end else begin
        want = pending_products.pop_front();
        if (out_ch.best_product !== want.product)
          report_mismatch("best_product", 64'(out_ch.best_product), 64'(want.product));
        if (out_ch.too_few !== want.too_few)
          report_mismatch("too_few", 64'(out_ch.too_few), 64'(want.too_few));
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_streaming_max_triplet_product_unit: done, errors");
        $finish;
      end
    end
  end

  // Drives one item from a falling edge and holds it until accepted.
  task automatic send_sample(input logic signed [SW-1:0] s, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= SW'($urandom);
      in_ch.final_item <= 1'($urandom);
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.sample     <= s;
    in_ch.final_item <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_items++;
  endtask

  // Sender goes quiet until every queued product has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    logic signed [SW-1:0] v;
    case ($urandom_range(9))
      0:       v = S_MAX;
      1:       v = S_MIN;
      2:       v = SW'($urandom_range(16) - 8);
      3:       v = SW'($urandom_range(S_MAX - 2, S_MAX));
      4:       v = SW'(-$urandom_range(30000, 32768));
      default: v = SW'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_set(input int len);
    for (int k = 0; k < len; k++)
      send_sample(pick_sample(), k == len - 1);
  endtask

  // extremes, reset-value samples, too-few sets, mixed signs
  task automatic test_extremes();
    send_sample(S_MAX, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MAX, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MIN, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    send_sample(S_MAX, 1'b1);                // single sample, too few
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b1);                // two samples, too few
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd2, 1'b0);
    send_sample(-16'sd3, 1'b1);
    wait_drained();
  endtask

  // back-to-back short sets load the product unit
  task automatic test_short_sets();
    for (int n = 0; n < 12; n++)
      send_set($urandom_range(1, 3));
    wait_drained();
  endtask

  task automatic test_random_sets(input int src_pct, input int snk_pct);
    int r;
    int goal;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    goal = sent_items + ITEMS_PER_PHASE;
    while (sent_items < goal) begin
      r = $urandom_range(99);
      if (r < 12)      send_set($urandom_range(1, 2));
      else if (r < 85) send_set($urandom_range(3, 8));
      else             send_set($urandom_range(9, 40));
    end
  endtask

  // pause mid-phase until everything has drained, then continue
  task automatic test_drain_pause();
    src_idle_pct = 0;
    snk_idle_pct = 58;
    send_set(5);
    send_set(2);
    wait_drained();
    send_set(4);
    wait_drained();
  endtask

  initial begin
    clear_tracker();
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.sample     = '0;
    in_ch.final_item = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_short_sets();
    test_random_sets(0, 0);
    test_drain_pause();
    test_random_sets(58, 0);
    test_random_sets(0, 58);
    test_random_sets(8, 8);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_products.size() != 0)
      report_mismatch("products never delivered", 64'(pending_products.size()), 64'd0);
    if (error_count == 0) begin
      $display("tb_streaming_max_triplet_product_unit: done, clean");
    end else begin
      $display("tb_streaming_max_triplet_product_unit: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/smtp_pkg.sv
rtl/core/smtp_in_if.sv
rtl/core/smtp_out_if.sv
rtl/core/smtp_front.sv
rtl/core/smtp_queue.sv
rtl/core/smtp_back.sv
rtl/core/streaming_max_triplet_product_unit.sv
sim/tb_streaming_max_triplet_product_unit.sv
